// ===== rtl/csm_pkg.sv =====
// Shared types and constants for the complex magnitude pipeline.
package csm_pkg;

   localparam int unsigned PART_WIDTH     = 16;
   localparam int unsigned ABS_WIDTH      = PART_WIDTH + 1;
   localparam int unsigned SQUARE_WIDTH   = 2 * PART_WIDTH - 1;
   localparam int unsigned ENERGY_WIDTH   = 2 * PART_WIDTH;
   localparam int unsigned ROOT_WIDTH     = PART_WIDTH;
   localparam int unsigned REM_WIDTH      = ROOT_WIDTH + 2;
   localparam int unsigned SQRT_STAGES    = ENERGY_WIDTH / 2;
   localparam logic [ROOT_WIDTH-1:0]   MAX_MAGNITUDE = 16'd46340;
   localparam logic [ENERGY_WIDTH-1:0] MAX_ENERGY    = 32'h8000_0000;
   localparam logic [SQUARE_WIDTH-1:0] MAX_SQUARE    = 31'h4000_0000;

   // One slot of the square-root pipeline.
   typedef struct packed {
      logic                    valid;
      logic [ROOT_WIDTH-1:0]   root;
      logic [REM_WIDTH-1:0]    rem;
      logic [ENERGY_WIDTH-1:0] radicand;
   } stage_type;

endpackage

// ===== rtl/csm_sqrt_stage.sv =====
// One digit step of the pipelined integer square root.
module csm_sqrt_stage (
   input  logic                clock,
   input  logic                reset,
   input  csm_pkg::stage_type  stage_in,
   output csm_pkg::stage_type  stage_out
);

   localparam int unsigned WIDE_WIDTH = csm_pkg::REM_WIDTH + 2;

   logic [WIDE_WIDTH-1:0] wide;
   logic [WIDE_WIDTH-1:0] trial;
   logic                  fits;

   logic                  valid_ff, valid_in;
   logic [csm_pkg::ROOT_WIDTH-1:0]   root_ff, root_in;
   logic [csm_pkg::REM_WIDTH-1:0]    rem_ff, rem_in;
   logic [csm_pkg::ENERGY_WIDTH-1:0] radicand_ff, radicand_in;

   // Bring down the next two radicand bits and try root*4+1.
   always_comb begin
      wide        = {stage_in.rem,
                     stage_in.radicand[csm_pkg::ENERGY_WIDTH-1 -: 2]};
      trial       = {2'b00, stage_in.root, 2'b01};
      fits        = (wide >= trial);
      rem_in      = fits ? csm_pkg::REM_WIDTH'(wide - trial)
                         : csm_pkg::REM_WIDTH'(wide);
      root_in     = {stage_in.root[csm_pkg::ROOT_WIDTH-2:0], fits};
      radicand_in = {stage_in.radicand[csm_pkg::ENERGY_WIDTH-3:0], 2'b00};
      valid_in    = stage_in.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      root_ff     <= root_in;
      rem_ff      <= rem_in;
      radicand_ff <= radicand_in;
   end

   assign stage_out = '{valid: valid_ff, root: root_ff, rem: rem_ff,
                        radicand: radicand_ff};

`ifndef SYNTHESIS
   // Partial remainder never exceeds twice the partial root.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (rem_ff <= {1'b0, root_ff, 1'b0}))
      else $error("sqrt stage remainder above 2*root");

   // Root shifts in exactly one new digit.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (root_ff[csm_pkg::ROOT_WIDTH-1:1] ==
                    $past(stage_in.root[csm_pkg::ROOT_WIDTH-2:0])))
      else $error("sqrt stage root did not shift by one digit");

   // Consumed radicand bits leave zeros behind.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (radicand_ff[1:0] == 2'b00))
      else $error("sqrt stage radicand not shifted by two bits");
`endif

endmodule

// ===== rtl/complex_magnitude_16bit_top.sv =====
// Top level of the pipelined 16-bit complex magnitude unit.
//
//   channel | ports                                  | handshake
//   --------+----------------------------------------+--------------------------
//   request | start, busy, req_real_part, req_imag_part | taken when start && !busy
//   result  | rsp_valid, rsp_magnitude               | one-cycle strobe, no stall
//
// Abs and squaring are registered, then the energy add, then one root digit per
// stage in a 16-stage digit-by-digit square root pipeline.
// A new transaction is taken every cycle; busy is always low, since the
// receiver cannot stall and nothing in the pipeline ever waits.
// Reset clears only the valid bits; data registers hold whatever they held.
module complex_magnitude_16bit_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic signed [15:0] req_real_part,
   input  logic signed [15:0] req_imag_part,
   output logic        rsp_valid,
   output logic [15:0] rsp_magnitude
);

   localparam int unsigned PW = csm_pkg::PART_WIDTH;
   localparam int unsigned AW = csm_pkg::ABS_WIDTH;
   localparam int unsigned SW = csm_pkg::SQUARE_WIDTH;
   localparam int unsigned EW = csm_pkg::ENERGY_WIDTH;
   localparam int unsigned NS = csm_pkg::SQRT_STAGES;

   // Stage 1: absolute values and squares.
   logic [AW-1:0]   real_ext, imag_ext;
   logic [AW-1:0]   real_abs, imag_abs;
   logic [2*AW-1:0] real_prod, imag_prod;

   logic            sq_valid_ff, sq_valid_in;
   logic [SW-1:0]   real_sq_ff, real_sq_in;
   logic [SW-1:0]   imag_sq_ff, imag_sq_in;

   // Stage 2: energy.
   logic            en_valid_ff, en_valid_in;
   logic [EW-1:0]   energy_ff, energy_in;

   csm_pkg::stage_type chain [0:NS];

   // Never hold off a transaction.
   assign busy = 1'b0;

   always_comb begin
      real_ext    = {req_real_part[PW-1], req_real_part};
      imag_ext    = {req_imag_part[PW-1], req_imag_part};
      real_abs    = req_real_part[PW-1] ? AW'({AW{1'b0}} - real_ext) : real_ext;
      imag_abs    = req_imag_part[PW-1] ? AW'({AW{1'b0}} - imag_ext) : imag_ext;
      real_prod   = real_abs * real_abs;
      imag_prod   = imag_abs * imag_abs;
      // Squares stay at or below 2^30, so the top bits are always zero.
      real_sq_in  = real_prod[SW-1:0];
      imag_sq_in  = imag_prod[SW-1:0];
      sq_valid_in = start && !busy;
   end

   // Sum of squares peaks at 2^31 and fits unsigned in 32 bits.
   always_comb begin
      energy_in   = {1'b0, real_sq_ff} + {1'b0, imag_sq_ff};
      en_valid_in = sq_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
         en_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff <= sq_valid_in;
         en_valid_ff <= en_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      real_sq_ff <= real_sq_in;
      imag_sq_ff <= imag_sq_in;
      energy_ff  <= energy_in;
   end

   // Seed the root pipeline: empty root, empty remainder, full radicand.
   assign chain[0] = '{valid: en_valid_ff, root: '0, rem: '0,
                       radicand: energy_ff};

   // Advance one root digit per stage.
   for (genvar i = 0; i < NS; i++) begin : g_sqrt
      csm_sqrt_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (chain[i]),
         .stage_out (chain[i+1])
      );
   end

   assign rsp_valid     = chain[NS].valid;
   assign rsp_magnitude = chain[NS].root;

`ifndef SYNTHESIS
   // Squares of a 16-bit signed value never pass 2^30.
   assert property (@(posedge clock) disable iff (reset)
      sq_valid_ff |-> (real_sq_ff <= csm_pkg::MAX_SQUARE &&
                       imag_sq_ff <= csm_pkg::MAX_SQUARE))
      else $error("square out of range");

   // Energy never passes 2^31.
   assert property (@(posedge clock) disable iff (reset)
      en_valid_ff |-> (energy_ff <= csm_pkg::MAX_ENERGY))
      else $error("energy out of range");

   // Magnitude never passes floor(sqrt(2^31)).
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_magnitude <= csm_pkg::MAX_MAGNITUDE))
      else $error("magnitude out of range");
`endif

endmodule
